// ----- hdl/zdfa_pkg.sv -----
// Shared types, constants and field widths for the zero-delimited frame FIFO.
`timescale 1ns / 1ps

package zdfa_pkg;

	// Default geometry
	localparam int RING_SLOTS_DEF = 8;
	localparam int MAX_FRAME_DEF  = 64;

	// Field widths
	localparam int BYTE_W  = 8;
	localparam int BIDX_W  = 6;
	localparam int FLEN_W  = 7;
	localparam int TIME_W  = 32;
	localparam int SDATA_W = 40;
	localparam int MDATA_W = 56;

	// Frame delimiter
	localparam logic [BYTE_W-1:0] DELIM = 8'h00;

	// Item kinds carried on the input tuser
	typedef enum logic {
		OP_RECEIVE = 1'b0,
		OP_POP     = 1'b1
	} op_t;

	// Controller states
	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EMIT = 1'b1
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic rx_en;
		logic pop_start;
		logic emit;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic out_free;
		logic last_item;
	} status_t;

endpackage

// ----- hdl/zdfa_ctrl.sv -----
// Controller state machine: accepts items and sequences the emission of a popped frame.
`timescale 1ns / 1ps

module zdfa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_op,
	output logic               in_ready,
	input  zdfa_pkg::status_t  status,
	output zdfa_pkg::cmd_t     cmd
);
	import zdfa_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   take;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d       = state_q;
		in_ready      = 1'b0;
		cmd           = '0;
		take          = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				take     = in_valid;
				if (take) begin
					if (op_t'(in_op) == OP_POP) begin
						cmd.pop_start = 1'b1;
						state_d       = ST_EMIT;
					end else begin
						cmd.rx_en = 1'b1;
					end
				end
			end
			ST_EMIT: begin
				// one result per cycle while the output register can take it
				if (status.out_free) begin
					cmd.emit = 1'b1;
					if (status.last_item) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- hdl/zdfa_dpath.sv -----
// Datapath: frame byte store, slot tables, ring pointers and the output register.
`timescale 1ns / 1ps

module zdfa_dpath #(
	parameter int RING_SLOTS = zdfa_pkg::RING_SLOTS_DEF,
	parameter int MAX_FRAME  = zdfa_pkg::MAX_FRAME_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  zdfa_pkg::cmd_t              cmd,
	output zdfa_pkg::status_t           status,
	input  logic [zdfa_pkg::BYTE_W-1:0] rx_byte,
	input  logic [zdfa_pkg::TIME_W-1:0] time_us,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [zdfa_pkg::MDATA_W-1:0] out_data,
	output logic                        out_flag,
	output logic                        out_last
);
	import zdfa_pkg::*;

	localparam int SLOT_W = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
	localparam int IDX_W  = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
	localparam int CNT_W  = $clog2(MAX_FRAME + 1);
	localparam int ADDR_W = SLOT_W + IDX_W;
	localparam int DEPTH  = RING_SLOTS * (2 ** IDX_W);

	// Storage
	logic [BYTE_W-1:0] byte_mem [DEPTH];
	logic [CNT_W-1:0]  len_mem  [RING_SLOTS];
	logic [TIME_W-1:0] time_mem [RING_SLOTS];

	// Control registers
	logic [CNT_W-1:0]  cnt_q;
	logic [SLOT_W-1:0] wr_slot_q;
	logic [SLOT_W-1:0] rd_slot_q;
	logic [IDX_W-1:0]  idx_q;
	logic              empty_q;
	logic              oval_q;

	// Registered reads and output payload
	logic [BYTE_W-1:0] byte_rd_q;
	logic [CNT_W-1:0]  len_rd_q;
	logic [TIME_W-1:0] time_rd_q;
	logic [BYTE_W-1:0] obyte_q;
	logic [BIDX_W-1:0] oidx_q;
	logic [FLEN_W-1:0] olen_q;
	logic [TIME_W-1:0] otime_q;
	logic              oflag_q;
	logic              olast_q;

	// Receive path
	logic              has_room;
	logic [CNT_W-1:0]  cnt_inc;
	logic              is_delim;
	logic [SLOT_W-1:0] wr_next;
	logic [SLOT_W-1:0] rd_next;
	logic              no_slot_free;
	logic              do_push;
	logic              byte_we;
	logic [ADDR_W-1:0] wr_addr;

	// Pop path
	logic [IDX_W-1:0]  idx_d;
	logic [ADDR_W-1:0] rd_addr;
	logic              last_item;

	assign has_room     = cnt_q < CNT_W'(MAX_FRAME);
	assign cnt_inc      = has_room ? cnt_q + CNT_W'(1) : cnt_q;
	assign is_delim     = rx_byte == DELIM;
	assign wr_next      = (wr_slot_q == SLOT_W'(RING_SLOTS - 1)) ? '0 : wr_slot_q + SLOT_W'(1);
	assign rd_next      = (rd_slot_q == SLOT_W'(RING_SLOTS - 1)) ? '0 : rd_slot_q + SLOT_W'(1);
	assign no_slot_free = wr_next == rd_slot_q;
	assign do_push      = cmd.rx_en && is_delim && (cnt_inc > CNT_W'(1)) && !no_slot_free;
	assign byte_we      = cmd.rx_en && has_room;
	// bytes land straight in the write slot; that slot is never read until pushed
	assign wr_addr      = {wr_slot_q, cnt_q[IDX_W-1:0]};

	// Read index for the next cycle
	always_comb begin
		if (cmd.pop_start) begin
			idx_d = '0;
		end else if (cmd.emit) begin
			idx_d = idx_q + IDX_W'(1);
		end else begin
			idx_d = idx_q;
		end
	end
	assign rd_addr = {rd_slot_q, idx_d};

	assign last_item = empty_q || ((CNT_W'(idx_q) + CNT_W'(1)) == len_rd_q);
	assign status.last_item = last_item;
	assign status.out_free  = !oval_q || out_ready;

	// Memories: byte store and slot tables
	always_ff @(posedge clk) begin
		if (byte_we) begin
			byte_mem[wr_addr] <= rx_byte;
		end
		byte_rd_q <= byte_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			len_mem[wr_slot_q]  <= cnt_inc;
			time_mem[wr_slot_q] <= time_us;
		end
		len_rd_q  <= len_mem[rd_slot_q];
		time_rd_q <= time_mem[rd_slot_q];
	end

	// Accumulated count, ring pointers and pop index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			wr_slot_q <= '0;
			rd_slot_q <= '0;
			idx_q     <= '0;
			empty_q   <= 1'b0;
		end else begin
			if (cmd.rx_en) begin
				cnt_q <= is_delim ? '0 : cnt_inc;
			end
			if (do_push) begin
				wr_slot_q <= wr_next;
			end
			if (cmd.pop_start) begin
				empty_q <= wr_slot_q == rd_slot_q;
			end
			if (cmd.emit && last_item && !empty_q) begin
				rd_slot_q <= rd_next;
			end
			idx_q <= idx_d;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oval_q <= 1'b0;
		end else if (cmd.emit) begin
			oval_q <= 1'b1;
		end else if (out_ready) begin
			oval_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			if (empty_q) begin
				obyte_q <= '0;
				oidx_q  <= '0;
				olen_q  <= '0;
				otime_q <= '0;
				oflag_q <= 1'b0;
			end else begin
				obyte_q <= byte_rd_q;
				oidx_q  <= BIDX_W'(idx_q);
				olen_q  <= FLEN_W'(len_rd_q);
				otime_q <= time_rd_q;
				oflag_q <= 1'b1;
			end
			olast_q <= last_item;
		end
	end

	assign out_valid = oval_q;
	assign out_data  = {3'b000, otime_q, olen_q, oidx_q, obyte_q};
	assign out_flag  = oflag_q;
	assign out_last  = olast_q;

endmodule

// ----- hdl/zero_delimited_frame_assembler_fifo_core.sv -----
// Top level of the zero-delimited frame assembler with frame FIFO.
// Receive transfers: one per cycle while idle, no result produced.
// Pop transfer: acceptance points the byte store's registered read port at byte 0, then one result
// per cycle while the output register can take it; the input stays not ready until the
// frame's last result (a single flagged-invalid result when the ring is empty) is emitted.
// Reset clears the byte count, ring pointers, controller state and output valid;
// stored frame contents are not cleared.
`timescale 1ns / 1ps

module zero_delimited_frame_assembler_fifo_core #(
	parameter int RING_SLOTS = zdfa_pkg::RING_SLOTS_DEF,
	parameter int MAX_FRAME  = zdfa_pkg::MAX_FRAME_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [zdfa_pkg::SDATA_W-1:0] s_axis_tdata,  // rx_byte[7:0], time_us[39:8]
	input  logic                         s_axis_tuser,  // operation
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [zdfa_pkg::MDATA_W-1:0] m_axis_tdata,  // out_byte[7:0], byte_index[13:8],
	                                                    // frame_length[20:14],
	                                                    // frame_time_us[52:21], zero pad
	output logic                         m_axis_tuser,  // frame_valid
	output logic                         m_axis_tlast   // last
);
	import zdfa_pkg::*;

	cmd_t    cmd;
	status_t status;

	// Controller
	zdfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_op    (s_axis_tuser),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// Datapath
	zdfa_dpath #(
		.RING_SLOTS (RING_SLOTS),
		.MAX_FRAME  (MAX_FRAME)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.rx_byte   (s_axis_tdata[BYTE_W-1:0]),
		.time_us   (s_axis_tdata[BYTE_W+TIME_W-1:BYTE_W]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_flag  (m_axis_tuser),
		.out_last  (m_axis_tlast)
	);

endmodule
